@@ sv/bca_pkg.sv @@
// Shared types and constants of the block chain allocator.
package bca_pkg;

    localparam int IDX_W           = 16;
    localparam int CNT_W           = 11;
    localparam int NUM_ENTRIES_DEF = 2048;

    localparam logic [IDX_W-1:0] CHAIN_END = 16'hFFFF;

    typedef enum logic [1:0] {
        REQ_ALLOC  = 2'd0,
        REQ_FREE   = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_LOOKUP = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BAD     = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t        req_type;
        logic [IDX_W-1:0] block_index;
        logic [CNT_W-1:0] block_count;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] result_index;
        logic [CNT_W-1:0] new_block;
        logic [CNT_W-1:0] freed_count;
    } rsp_t;

endpackage

@@ sv/bca_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module bca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

@@ sv/block_chain_allocator.sv @@
// Top level of the block chain allocator: link table RAM and request sequencer.
//
// Sequence: lookup reads the entry; free clears along the chain; append walks to the tail,
// scans for the lowest free index and links it on; allocate counts free entries in a first
// scan over the table and links them in a second. Bad heads and empty allocations answer
// in the cycle after accept. Throughput: one transaction at a time; the table RAM's single
// read port, one entry a cycle, sets the rate. After reset, busy stays high while the table
// is swept to zero. The done strobe lasts one cycle and cannot be stalled.
module block_chain_allocator #(
    parameter int NUM_ENTRIES = bca_pkg::NUM_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  bca_pkg::req_t req,
    output logic          done,
    output bca_pkg::rsp_t rsp
);

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int IW = bca_pkg::IDX_W;
    localparam int CW = bca_pkg::CNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

    // S_CNT/S_LINK: allocate count and link passes; S_WALK/S_FIND/S_ATAIL: append.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT,
        S_LINK,
        S_AEND,
        S_FREE,
        S_WALK,
        S_FIND,
        S_ATAIL,
        S_LOOK
    } state_t;

    state_t          state_reg, state_next;
    logic [IW-1:0]   scan_reg, scan_next;
    logic [IW-1:0]   rd_idx_reg, rd_idx_next;
    logic            rd_valid_reg, rd_valid_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic [IW-1:0]   prev_reg, prev_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   steps_reg, steps_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   n_reg, n_next;
    logic            done_reg, done_next;
    bca_pkg::rsp_t   rsp_reg, rsp_next;
    logic            fwd_hit_reg;
    logic [IW-1:0]   fwd_data_reg;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [IW-1:0]   wr_data;
    logic [AW-1:0]   rd_addr;
    logic [IW-1:0]   ram_rdata;
    logic [IW-1:0]   d;
    logic            hit;
    logic            at_last;
    logic            head_bad;
    logic [CW-1:0]   cnt_inc;
    logic [IW-1:0]   steps_inc;

    bca_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Forward a write that landed on the entry read in the same cycle.
    assign d         = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign hit       = rd_valid_reg && (d == '0);
    assign at_last   = rd_valid_reg && (rd_idx_reg == LAST_IDX);
    assign head_bad  = (req.block_index == '0) || (req.block_index > LAST_IDX);
    assign cnt_inc   = cnt_reg + CW'(1);
    assign steps_inc = steps_reg + IW'(1);

    always_comb
    begin
        state_next    = state_reg;
        scan_next     = scan_reg;
        rd_idx_next   = scan_reg;
        rd_valid_next = 1'b0;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        head_next     = head_reg;
        steps_next    = steps_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        rd_addr       = scan_reg[AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the table to zero, one entry a cycle.
                wr_en   = 1'b1;
                wr_addr = scan_reg[AW-1:0];
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + IW'(1);
                end
            end

            S_IDLE:
            begin
                // Read the request's entry speculatively; free, append and lookup use it.
                rd_addr = req.block_index[AW-1:0];
                if (start)
                begin
                    rsp_next   = '0;
                    cur_next   = req.block_index;
                    prev_next  = '0;
                    head_next  = '0;
                    steps_next = '0;
                    cnt_next   = '0;
                    n_next     = req.block_count;
                    scan_next  = IW'(1);
                    unique case (req.req_type)
                        bca_pkg::REQ_ALLOC:
                        begin
                            if (req.block_count == '0)
                            begin
                                rsp_next.result_index = bca_pkg::CHAIN_END;
                                done_next             = 1'b1;
                            end
                            else
                            begin
                                state_next = S_CNT;
                            end
                        end
                        bca_pkg::REQ_FREE:
                        begin
                            if (head_bad)
                            begin
                                rsp_next.status = bca_pkg::ST_BAD;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FREE;
                            end
                        end
                        bca_pkg::REQ_APPEND:
                        begin
                            if (head_bad)
                            begin
                                rsp_next.status = bca_pkg::ST_BAD;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        bca_pkg::REQ_LOOKUP:
                        begin
                            if (req.block_index > LAST_IDX)
                            begin
                                rsp_next.status = bca_pkg::ST_BAD;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                state_next = S_LOOK;
                            end
                        end
                    endcase
                end
            end

            S_CNT:
            begin
                // Count free entries until enough are seen or the table ends.
                rd_valid_next = 1'b1;
                scan_next     = scan_reg + IW'(1);
                if (hit && (cnt_inc == n_reg))
                begin
                    state_next    = S_LINK;
                    cnt_next      = '0;
                    scan_next     = IW'(1);
                    rd_valid_next = 1'b0;
                end
                else if (at_last)
                begin
                    rsp_next.status = bca_pkg::ST_NOSPACE;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (hit)
                begin
                    cnt_next = cnt_inc;
                end
            end

            S_LINK:
            begin
                // Link each free entry behind the previous one; writes stay behind the scan.
                rd_valid_next = 1'b1;
                scan_next     = scan_reg + IW'(1);
                if (hit)
                begin
                    if (prev_reg == '0)
                    begin
                        head_next = rd_idx_reg;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = prev_reg[AW-1:0];
                        wr_data = rd_idx_reg;
                    end
                    prev_next = rd_idx_reg;
                    cnt_next  = cnt_inc;
                    if (cnt_inc == n_reg)
                    begin
                        state_next = S_AEND;
                    end
                end
            end

            S_AEND:
            begin
                wr_en                 = 1'b1;
                wr_addr               = prev_reg[AW-1:0];
                wr_data               = bca_pkg::CHAIN_END;
                rsp_next.result_index = head_reg;
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            S_FREE:
            begin
                // d is the link of cur; clear and follow it in the same cycle.
                rd_addr = d[AW-1:0];
                if (d == '0)
                begin
                    rsp_next.status      = bca_pkg::ST_BAD;
                    rsp_next.freed_count = cnt_reg;
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg[AW-1:0];
                    wr_data  = '0;
                    cnt_next = cnt_inc;
                    cur_next = d;
                    if (d > LAST_IDX)
                    begin
                        rsp_next.status      = (d == bca_pkg::CHAIN_END) ? bca_pkg::ST_OK
                                                                         : bca_pkg::ST_BAD;
                        rsp_next.freed_count = cnt_inc;
                        done_next            = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
            end

            S_WALK:
            begin
                // Follow links to the tail; give up on a broken or overlong chain.
                rd_addr = d[AW-1:0];
                if (d == bca_pkg::CHAIN_END)
                begin
                    state_next = S_FIND;
                    scan_next  = IW'(1);
                end
                else if ((d == '0) || (d > LAST_IDX) || (steps_inc > LAST_IDX))
                begin
                    rsp_next.status = bca_pkg::ST_BAD;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cur_next   = d;
                    steps_next = steps_inc;
                end
            end

            S_FIND:
            begin
                // Scan for the lowest free entry; cur holds the tail.
                rd_valid_next = 1'b1;
                scan_next     = scan_reg + IW'(1);
                if (hit)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = rd_idx_reg[AW-1:0];
                    wr_data    = bca_pkg::CHAIN_END;
                    prev_next  = rd_idx_reg;
                    state_next = S_ATAIL;
                end
                else if (at_last)
                begin
                    rsp_next.status       = bca_pkg::ST_NOSPACE;
                    rsp_next.result_index = cur_reg;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            S_ATAIL:
            begin
                wr_en                 = 1'b1;
                wr_addr               = cur_reg[AW-1:0];
                wr_data               = prev_reg;
                rsp_next.result_index = cur_reg;
                rsp_next.new_block    = prev_reg[CW-1:0];
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            S_LOOK:
            begin
                rsp_next.result_index = d;
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            scan_reg     <= '0;
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            head_reg     <= '0;
            steps_reg    <= '0;
            cnt_reg      <= '0;
            n_reg        <= '0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
            fwd_hit_reg  <= 1'b0;
            fwd_data_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            rd_idx_reg   <= rd_idx_next;
            rd_valid_reg <= rd_valid_next;
            cur_reg      <= cur_next;
            prev_reg     <= prev_next;
            head_reg     <= head_next;
            steps_reg    <= steps_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // An accepted transaction either keeps the block busy or answers at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither started nor answered");

    // A result is only shown once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // The table is never written while the sequencer is idle.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("table write while idle");

    // Link writes trail the scan and never hit the entry being read.
    a_link_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && (state_reg == S_LINK)) |-> (wr_addr != rd_addr))
        else $error("link write collides with scan read");

    // The free count in the first pass stays below the requested length.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CNT) |-> (cnt_reg < n_reg))
        else $error("free count passed requested length");

endmodule

@@ test/tb_block_chain_allocator.sv @@
// Testbench for block_chain_allocator: directed and random requests against a table model.
`timescale 1ns / 100ps

module tb_block_chain_allocator;

    localparam int ENTRIES = bca_pkg::NUM_ENTRIES_DEF;
    localparam int IDX_W   = bca_pkg::IDX_W;
    localparam int CNT_W   = bca_pkg::CNT_W;

    // One row of the directed script: the request, and a typed-in response where the
    // answer is obvious (otherwise the table model supplies it).
    typedef struct packed {
        bca_pkg::req_t req;
        logic          typed;
        bca_pkg::rsp_t rsp;
    } script_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    bca_pkg::req_t req;
    logic          done;
    bca_pkg::rsp_t rsp;

    // Model of the link table: 0 marks a free block, CHAIN_END ends a chain.
    logic [IDX_W-1:0] link_mem [ENTRIES];

    // Responses still owed by the block, oldest first.
    bca_pkg::rsp_t awaited[$];

    script_row_t script[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_by_type [4];

    block_chain_allocator #(
        .NUM_ENTRIES(ENTRIES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every request a full double scan).
    initial
    begin
        #60_000_000;
        $display("%0t: timeout, %0d responses still outstanding", $time, awaited.size());
        $display("Mismatches found");
        $finish;
    end

    // Apply one request to the model table and return the response it must produce.
    function automatic bca_pkg::rsp_t table_response(bca_pkg::req_t r);
        bca_pkg::rsp_t o;
        int unsigned   i;
        int unsigned   avail;
        int unsigned   taken;
        int unsigned   prev;
        int unsigned   head;
        int unsigned   cur;
        int unsigned   cnt;
        int unsigned   steps;
        int unsigned   nxt;
        int unsigned   fresh;
        bit            broken;
        o        = '0;
        o.status = bca_pkg::ST_OK;
        case (r.req_type)
            bca_pkg::REQ_ALLOC:
            begin
                cnt = r.block_count;
                if (cnt == 0)
                    o.result_index = bca_pkg::CHAIN_END;
                else
                begin
                    // Count first; leave the table untouched when space runs short.
                    avail = 0;
                    for (i = 1; i < ENTRIES && avail < cnt; i++)
                        if (link_mem[i] == 0)
                            avail++;
                    if (avail < cnt)
                        o.status = bca_pkg::ST_NOSPACE;
                    else
                    begin
                        taken = 0;
                        prev  = 0;
                        head  = 0;
                        for (i = 1; i < ENTRIES && taken < cnt; i++)
                        begin
                            if (link_mem[i] == 0)
                            begin
                                if (prev == 0)
                                    head = i;
                                else
                                    link_mem[prev] = i[IDX_W-1:0];
                                prev = i;
                                taken++;
                            end
                        end
                        link_mem[prev] = bca_pkg::CHAIN_END;
                        o.result_index = head[IDX_W-1:0];
                    end
                end
            end
            bca_pkg::REQ_FREE:
            begin
                // Clear along the chain until a free or out-of-range link; count what went.
                cur = r.block_index;
                cnt = 0;
                while (cur > 0 && cur < ENTRIES && link_mem[cur] != 0)
                begin
                    nxt           = link_mem[cur];
                    link_mem[cur] = '0;
                    cnt++;
                    cur = nxt;
                end
                o.status      = (cur == bca_pkg::CHAIN_END && cnt > 0) ? bca_pkg::ST_OK
                                                                       : bca_pkg::ST_BAD;
                o.freed_count = cnt[CNT_W-1:0];
            end
            bca_pkg::REQ_APPEND:
            begin
                cur = r.block_index;
                if (cur == 0 || cur >= ENTRIES || link_mem[cur] == 0)
                    o.status = bca_pkg::ST_BAD;
                else
                begin
                    steps  = 0;
                    broken = 1'b0;
                    while (!broken && link_mem[cur] != bca_pkg::CHAIN_END)
                    begin
                        nxt = link_mem[cur];
                        steps++;
                        if (nxt == 0 || nxt >= ENTRIES || steps >= ENTRIES)
                            broken = 1'b1;
                        else
                            cur = nxt;
                    end
                    if (broken)
                        o.status = bca_pkg::ST_BAD;
                    else
                    begin
                        o.result_index = cur[IDX_W-1:0];
                        fresh = 0;
                        for (i = 1; i < ENTRIES && fresh == 0; i++)
                            if (link_mem[i] == 0)
                                fresh = i;
                        if (fresh == 0)
                            o.status = bca_pkg::ST_NOSPACE;
                        else
                        begin
                            link_mem[fresh] = bca_pkg::CHAIN_END;
                            link_mem[cur]   = fresh[IDX_W-1:0];
                            o.new_block     = fresh[CNT_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                if (r.block_index < ENTRIES)
                    o.result_index = link_mem[r.block_index];
                else
                    o.status = bca_pkg::ST_BAD;
            end
        endcase
        return o;
    endfunction

    function automatic void add_row(bca_pkg::req_type_t t, int unsigned idx,
                                    int unsigned cnt, bit typed, bca_pkg::status_t st,
                                    int unsigned res, int unsigned nb, int unsigned fc);
        script_row_t s;
        s.req.req_type       = t;
        s.req.block_index    = idx[IDX_W-1:0];
        s.req.block_count    = cnt[CNT_W-1:0];
        s.typed              = typed;
        s.rsp.status         = st;
        s.rsp.result_index   = res[IDX_W-1:0];
        s.rsp.new_block      = nb[CNT_W-1:0];
        s.rsp.freed_count    = fc[CNT_W-1:0];
        script.push_back(s);
    endfunction

    // Drive one transaction. Hold start high across back-to-back requests so that it
    // never gets two assignments in one time step; drop it only for an idle gap.
    task automatic issue(input bca_pkg::req_t r, input bit typed,
                         input bca_pkg::rsp_t typed_rsp, input bit may_idle,
                         output bca_pkg::rsp_t pred);
        int unsigned gap;
        gap = may_idle ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        // Accepted at the first rising edge that sees busy low.
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = table_response(r);
        awaited.push_back(typed ? typed_rsp : pred);
        n_by_type[r.req_type]++;
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Response checker: every done strobe must match the oldest owed response.
    always @(posedge clk)
    begin
        bca_pkg::rsp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: response with none expected, got %p", $time, rsp);
            end
            else
            begin
                want = awaited.pop_front();
                checked++;
                check_field("status", want.status, rsp.status);
                check_field("result_index", want.result_index, rsp.result_index);
                check_field("new_block", want.new_block, rsp.new_block);
                check_field("freed_count", want.freed_count, rsp.freed_count);
            end
        end
    end

    initial
    begin
        bca_pkg::req_t r;
        bca_pkg::rsp_t p;
        int unsigned   k;
        int unsigned   pick;
        int unsigned   sz;
        int unsigned   h;
        bit            from_list;
        bit            quiet;
        int unsigned   live[$];

        rst_n  = 1'b0;
        start  = 1'b0;
        req    = '0;
        errors = 0;
        checked = 0;
        for (k = 0; k < 4; k++)
            n_by_type[k] = 0;
        for (k = 0; k < ENTRIES; k++)
            link_mem[k] = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed script. Bounds of the index, bad heads, the empty allocation,
        // a broken chain for append and free, a full table and a full-length chain.
        add_row(bca_pkg::REQ_LOOKUP, 0, 5, 1, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_LOOKUP, ENTRIES - 1, 0, 1, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_LOOKUP, ENTRIES, 0, 1, bca_pkg::ST_BAD, 0, 0, 0);
        add_row(bca_pkg::REQ_LOOKUP, 65535, 2047, 1, bca_pkg::ST_BAD, 0, 0, 0);
        add_row(bca_pkg::REQ_FREE, 0, 0, 1, bca_pkg::ST_BAD, 0, 0, 0);
        add_row(bca_pkg::REQ_FREE, 65535, 0, 1, bca_pkg::ST_BAD, 0, 0, 0);
        add_row(bca_pkg::REQ_APPEND, 0, 0, 1, bca_pkg::ST_BAD, 0, 0, 0);
        add_row(bca_pkg::REQ_APPEND, ENTRIES, 0, 1, bca_pkg::ST_BAD, 0, 0, 0);
        add_row(bca_pkg::REQ_APPEND, 9, 0, 1, bca_pkg::ST_BAD, 0, 0, 0);
        add_row(bca_pkg::REQ_ALLOC, 0, 0, 1, bca_pkg::ST_OK, 65535, 0, 0);
        add_row(bca_pkg::REQ_ALLOC, 0, 3, 1, bca_pkg::ST_OK, 1, 0, 0);
        add_row(bca_pkg::REQ_LOOKUP, 1, 0, 0, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_APPEND, 1, 0, 0, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_ALLOC, 0, 2, 0, bca_pkg::ST_OK, 0, 0, 0);
        // Free from the middle leaves block 1 pointing at a free entry.
        add_row(bca_pkg::REQ_FREE, 2, 0, 0, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_APPEND, 1, 0, 0, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_FREE, 1, 0, 0, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_FREE, 3, 0, 0, bca_pkg::ST_OK, 0, 0, 0);
        add_row(bca_pkg::REQ_ALLOC, 0, 2047, 1, bca_pkg::ST_NOSPACE, 0, 0, 0);
        add_row(bca_pkg::REQ_FREE, 5, 0, 0, bca_pkg::ST_OK, 0, 0, 0);
        // Whole table in one chain: append finds no room, free clears all of it.
        add_row(bca_pkg::REQ_ALLOC, 0, 2047, 1, bca_pkg::ST_OK, 1, 0, 0);
        add_row(bca_pkg::REQ_APPEND, 1, 0, 1, bca_pkg::ST_NOSPACE, ENTRIES - 1, 0, 0);
        add_row(bca_pkg::REQ_LOOKUP, ENTRIES - 1, 0, 1, bca_pkg::ST_OK, 65535, 0, 0);
        add_row(bca_pkg::REQ_FREE, 1, 0, 1, bca_pkg::ST_OK, 0, 0, 2047);
        add_row(bca_pkg::REQ_ALLOC, 65535, 1, 1, bca_pkg::ST_OK, 1, 0, 0);

        foreach (script[i])
            issue(script[i].req, script[i].typed, script[i].rsp, 1'b1, p);

        // Random part: mostly frees and appends on live chains, with small
        // allocations, some large ones, and stray indexes as noise.
        live.push_back(1);
        for (k = 0; k < 265; k++)
        begin
            quiet         = ((k / 40) % 3) == 2;
            from_list     = 1'b0;
            h             = 0;
            r.block_index = 16'($urandom());
            r.block_count = 11'($urandom());
            pick          = $urandom_range(0, 99);
            // Keep the table from clogging: force a free when many chains are alive.
            if (live.size() > 24)
                pick = 40;
            if (pick < 30)
            begin
                r.req_type = bca_pkg::REQ_ALLOC;
                sz = $urandom_range(0, 99);
                if (sz < 88)
                    r.block_count = 11'($urandom_range(1, 6));
                else if (sz < 97)
                    r.block_count = 11'($urandom_range(7, 64));
                else
                    r.block_count = 11'($urandom_range(0, 2047));
            end
            else if (pick < 80)
            begin
                r.req_type = (pick < 55) ? bca_pkg::REQ_FREE : bca_pkg::REQ_APPEND;
                if (live.size() != 0 && $urandom_range(0, 9) < 8)
                begin
                    h             = $urandom_range(0, live.size() - 1);
                    r.block_index = live[h][IDX_W-1:0];
                    from_list     = 1'b1;
                end
                else if ($urandom_range(0, 1) == 1)
                    r.block_index = 16'($urandom_range(0, ENTRIES - 1));
            end
            else
            begin
                r.req_type = bca_pkg::REQ_LOOKUP;
                if ($urandom_range(0, 4) != 0)
                    r.block_index = 16'($urandom_range(0, ENTRIES - 1));
            end

            issue(r, 1'b0, '0, !quiet, p);

            if (r.req_type == bca_pkg::REQ_ALLOC && p.status == bca_pkg::ST_OK
                && r.block_count != 0)
                live.push_back(32'(p.result_index));
            if (r.req_type == bca_pkg::REQ_FREE && from_list)
                live.delete(h);
        end

        @(negedge clk);
        start <= 1'b0;

        // Drain, then watch a little longer for stray strobes.
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Ran %0d allocate, %0d free, %0d append and %0d lookup requests",
                 n_by_type[bca_pkg::REQ_ALLOC], n_by_type[bca_pkg::REQ_FREE],
                 n_by_type[bca_pkg::REQ_APPEND], n_by_type[bca_pkg::REQ_LOOKUP]);
        $display("Checked %0d responses, %0d field errors", checked, errors);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ block_chain_allocator.f @@
sv/bca_pkg.sv
sv/bca_ram.sv
sv/block_chain_allocator.sv
test/tb_block_chain_allocator.sv
